@@ rtl/tun_pkg.sv @@
// Package for the triangle unit normal block: widths, word types and the side-band struct.
// Depends on nothing; every module of the block refers to it by scoped names.
package tun_pkg;

	// Input coordinate width (signed Q8.8) and output fraction bits (signed Q1.14).
	localparam int CW = 16;
	localparam int F = 14;

	// Derived widths.
	localparam int EW = CW + 1;          // edge vector component
	localparam int PW = 2 * EW;          // one cross-product term
	localparam int NW = PW + 1;          // cross-product component, signed
	localparam int MW = 2 * EW;          // magnitude of a component
	localparam int HW = MW / 2;          // half of a magnitude, for split squaring
	localparam int SQW = 2 * MW;         // square of a magnitude
	localparam int SW = SQW + 2;         // sum of three squares
	localparam int QW = F + 1;           // unsigned quotient
	localparam int UW = F + 2;           // signed unit component
	localparam int WW = SW + 2 * QW + 1; // remainder and partial-product width

	// Input word: three vertices.
	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by_coord;
		logic signed [CW-1:0] bz;
		logic signed [CW-1:0] cx;
		logic signed [CW-1:0] cy;
		logic signed [CW-1:0] cz;
	} tri_in_t;

	// Result word: unit normal and degenerate flag.
	typedef struct packed {
		logic signed [UW-1:0] unit_x;
		logic signed [UW-1:0] unit_y;
		logic signed [UW-1:0] unit_z;
		logic degenerate;
	} tri_out_t;

	// Control that travels beside the data of one word.
	typedef struct packed {
		logic vld;
		logic [2:0] neg;
		logic zero;
	} side_t;

endpackage

@@ rtl/tun_cross.sv @@
// Edge vectors, cross product and component magnitudes: pipeline stages one to three.
// Depends on tun_pkg.
module tun_cross (
	input  logic clk,
	input  logic arst_n,
	input  logic vld,
	input  tun_pkg::tri_in_t vertices,
	output logic vld_out,
	output logic [2:0] neg,
	output logic [2:0][tun_pkg::MW-1:0] mag
);

	logic signed [tun_pkg::EW-1:0] e_s1 [3];
	logic signed [tun_pkg::EW-1:0] f_s1 [3];
	logic signed [tun_pkg::PW-1:0] p_s2 [6];
	logic signed [tun_pkg::NW-1:0] n_c [3];
	logic [tun_pkg::NW-1:0] abs_c [3];
	logic [2:0] neg_s3;
	logic [2:0][tun_pkg::MW-1:0] mag_s3;
	logic vld_s1, vld_s2, vld_s3;

	// Valid bits follow the data through the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Stage one: edges from the first vertex, one bit wider than a coordinate.
	always_ff @(posedge clk) begin
		e_s1[0] <= {vertices.bx[tun_pkg::CW-1], vertices.bx}
			- {vertices.ax[tun_pkg::CW-1], vertices.ax};
		e_s1[1] <= {vertices.by_coord[tun_pkg::CW-1], vertices.by_coord}
			- {vertices.ay[tun_pkg::CW-1], vertices.ay};
		e_s1[2] <= {vertices.bz[tun_pkg::CW-1], vertices.bz}
			- {vertices.az[tun_pkg::CW-1], vertices.az};
		f_s1[0] <= {vertices.cx[tun_pkg::CW-1], vertices.cx}
			- {vertices.ax[tun_pkg::CW-1], vertices.ax};
		f_s1[1] <= {vertices.cy[tun_pkg::CW-1], vertices.cy}
			- {vertices.ay[tun_pkg::CW-1], vertices.ay};
		f_s1[2] <= {vertices.cz[tun_pkg::CW-1], vertices.cz}
			- {vertices.az[tun_pkg::CW-1], vertices.az};
	end

	// Stage two: the six products of the cross product.
	always_ff @(posedge clk) begin
		p_s2[0] <= e_s1[1] * f_s1[2];
		p_s2[1] <= e_s1[2] * f_s1[1];
		p_s2[2] <= e_s1[2] * f_s1[0];
		p_s2[3] <= e_s1[0] * f_s1[2];
		p_s2[4] <= e_s1[0] * f_s1[1];
		p_s2[5] <= e_s1[1] * f_s1[0];
	end

	// Stage three: component differences, split into sign and magnitude.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			n_c[k] = {p_s2[2*k][tun_pkg::PW-1], p_s2[2*k]}
				- {p_s2[2*k+1][tun_pkg::PW-1], p_s2[2*k+1]};
			abs_c[k] = n_c[k][tun_pkg::NW-1] ? (~n_c[k] + 1'b1) : n_c[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s3[k] <= n_c[k][tun_pkg::NW-1];
			mag_s3[k] <= abs_c[k][tun_pkg::MW-1:0];
		end
	end

	assign vld_out = vld_s3;
	assign neg = neg_s3;
	assign mag = mag_s3;

endmodule

@@ rtl/tun_norm.sv @@
// Squares of the components and their sum, the squared length: pipeline stages four to six.
// Depends on tun_pkg.
module tun_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic vld,
	input  logic [2:0] neg,
	input  logic [2:0][tun_pkg::MW-1:0] mag,
	output tun_pkg::side_t side,
	output logic [tun_pkg::SW-1:0] sum,
	output logic [2:0][tun_pkg::WW-1:0] rem0
);

	logic [2:0][2*tun_pkg::HW-1:0] hh_s4, hl_s4, ll_s4;
	logic [2:0][tun_pkg::SQW-1:0] sq_s5;
	logic [tun_pkg::SW-1:0] sum_s6;
	logic [2:0][tun_pkg::WW-1:0] rem_s6;
	logic vld_s4, vld_s5, vld_s6;
	logic [2:0] neg_s4, neg_s5, neg_s6;
	logic zero_s6;

	// Valid bits and signs travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s4 <= vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage four: partial products of each square from the two halves.
	always_ff @(posedge clk) begin
		neg_s4 <= neg;
		for (int k = 0; k < 3; k++) begin
			hh_s4[k] <= mag[k][tun_pkg::MW-1:tun_pkg::HW] * mag[k][tun_pkg::MW-1:tun_pkg::HW];
			hl_s4[k] <= mag[k][tun_pkg::MW-1:tun_pkg::HW] * mag[k][tun_pkg::HW-1:0];
			ll_s4[k] <= mag[k][tun_pkg::HW-1:0] * mag[k][tun_pkg::HW-1:0];
		end
	end

	// Stage five: assemble each square.
	always_ff @(posedge clk) begin
		neg_s5 <= neg_s4;
		for (int k = 0; k < 3; k++) begin
			sq_s5[k] <= {hh_s4[k], {tun_pkg::MW{1'b0}}}
				+ ({{(tun_pkg::SQW-2*tun_pkg::HW){1'b0}}, hl_s4[k]} << (tun_pkg::HW + 1))
				+ {{(tun_pkg::SQW-2*tun_pkg::HW){1'b0}}, ll_s4[k]};
		end
	end

	// Stage six: squared length, scaled starting remainders and the degenerate test.
	always_ff @(posedge clk) begin
		neg_s6 <= neg_s5;
		sum_s6 <= {2'b00, sq_s5[0]} + {2'b00, sq_s5[1]} + {2'b00, sq_s5[2]};
		zero_s6 <= (sq_s5[0] == '0) && (sq_s5[1] == '0) && (sq_s5[2] == '0);
		for (int k = 0; k < 3; k++) begin
			rem_s6[k] <= {{(tun_pkg::WW-tun_pkg::SQW-2*tun_pkg::F){1'b0}}, sq_s5[k],
				{(2*tun_pkg::F){1'b0}}};
		end
	end

	assign side.vld = vld_s6;
	assign side.neg = neg_s6;
	assign side.zero = zero_s6;
	assign sum = sum_s6;
	assign rem0 = rem_s6;

endmodule

@@ rtl/tun_lane.sv @@
// One division lane: restoring digit recurrence for q = floor(mag * 2^F / length),
// one quotient bit per pipeline stage. Depends on tun_pkg.
module tun_lane (
	input  logic clk,
	input  logic [tun_pkg::SW-1:0] sum,
	input  logic [tun_pkg::WW-1:0] rem0,
	output logic [tun_pkg::QW-1:0] q
);

	localparam int N = tun_pkg::QW;

	// Stage k keeps rem = mag^2*2^(2F) - q^2*S, prod = q*S, and the quotient so far.
	logic [tun_pkg::WW-1:0] rem_s [N];
	logic [tun_pkg::WW-1:0] prod_s [N];
	logic [tun_pkg::SW-1:0] sum_s [N];
	logic [tun_pkg::QW-1:0] q_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int B = tun_pkg::F - k;
		logic [tun_pkg::WW-1:0] rem_in, prod_in, sum_w, delta;
		logic [tun_pkg::SW-1:0] sum_in;
		logic [tun_pkg::QW-1:0] q_in;
		logic take;

		if (k == 0) begin : g_first
			assign rem_in = rem0;
			assign prod_in = '0;
			assign sum_in = sum;
			assign q_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign prod_in = prod_s[k-1];
			assign sum_in = sum_s[k-1];
			assign q_in = q_s[k-1];
		end

		// (q + 2^B)^2 * S - q^2 * S = q*S*2^(B+1) + S*2^(2B).
		assign sum_w = {{(tun_pkg::WW-tun_pkg::SW){1'b0}}, sum_in};
		assign delta = (prod_in << (B + 1)) + (sum_w << (2 * B));
		assign take = (delta <= rem_in);

		always_ff @(posedge clk) begin
			rem_s[k] <= take ? (rem_in - delta) : rem_in;
			prod_s[k] <= take ? (prod_in + (sum_w << B)) : prod_in;
			q_s[k] <= take ? (q_in | (tun_pkg::QW'(1) << B)) : q_in;
			sum_s[k] <= sum_in;
		end
	end

	assign q = q_s[N-1];

endmodule

@@ rtl/triangle_unit_normal_unit.sv @@
// Triangle unit normal: one word accepted every cycle.
// Stages: three for edges and cross product, three for the squared length, fifteen for the
// bit-per-stage division lanes, and one output register. busy is always low; the result
// cannot be stalled. Reset clears the valid bits and the done strobe; no clearing pass.
// Depends on tun_pkg, tun_cross, tun_norm and tun_lane.
module triangle_unit_normal_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  tun_pkg::tri_in_t vertices,
	output logic done,
	output tun_pkg::tri_out_t normal
);

	localparam int N = tun_pkg::QW;

	logic vld_s3;
	logic [2:0] neg_s3;
	logic [2:0][tun_pkg::MW-1:0] mag_s3;
	tun_pkg::side_t side_s6;
	logic [tun_pkg::SW-1:0] sum_s6;
	logic [2:0][tun_pkg::WW-1:0] rem_s6;
	logic [2:0][tun_pkg::QW-1:0] q_w;
	tun_pkg::side_t side_s [N];
	logic [2:0][tun_pkg::UW-1:0] unit_c;
	logic done_q;
	tun_pkg::tri_out_t normal_q;

	assign busy = 1'b0;

	tun_cross u_cross (
		.clk(clk), .arst_n(arst_n), .vld(start), .vertices(vertices),
		.vld_out(vld_s3), .neg(neg_s3), .mag(mag_s3)
	);

	tun_norm u_norm (
		.clk(clk), .arst_n(arst_n), .vld(vld_s3), .neg(neg_s3), .mag(mag_s3),
		.side(side_s6), .sum(sum_s6), .rem0(rem_s6)
	);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		tun_lane u_lane (.clk(clk), .sum(sum_s6), .rem0(rem_s6[c]), .q(q_w[c]));
	end

	// Side-band line that keeps valid, signs and degenerate flag aligned with the lanes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				side_s[k] <= '0;
			end
		end else begin
			side_s[0] <= side_s6;
			for (int k = 1; k < N; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// Apply the signs, and force zero for a degenerate triangle.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (side_s[N-1].zero) begin
				unit_c[c] = '0;
			end else if (side_s[N-1].neg[c]) begin
				unit_c[c] = '0 - {1'b0, q_w[c]};
			end else begin
				unit_c[c] = {1'b0, q_w[c]};
			end
		end
	end

	// Output register and done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_s[N-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		normal_q.unit_x <= unit_c[0];
		normal_q.unit_y <= unit_c[1];
		normal_q.unit_z <= unit_c[2];
		normal_q.degenerate <= side_s[N-1].zero;
	end

	assign done = done_q;
	assign normal = normal_q;

endmodule
